@@ hdl/dfs_pkg.sv @@
// ----------------------------------------------------------------------------
// dfs_pkg: shared types and constants of the delimited field splitter
// Beat payloads of the input and result channels, event codes, register
// indexes and the fixed byte values used by the splitter.
// ----------------------------------------------------------------------------
package dfs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_SEP_BYTES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_SEP_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SEP_BYTES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SEP_LEN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLLAPSE_REPEATS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_CRLF        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COMMENT_BYTES    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COMMENT_LEN      = 3'd7;

  // event kinds
  localparam logic [1:0] KIND_BYTE       = 2'd0;
  localparam logic [1:0] KIND_FIELD_END  = 2'd1;
  localparam logic [1:0] KIND_RECORD_END = 2'd2;

  localparam logic [7:0] LF_BYTE = 8'h0A;
  localparam logic [7:0] CR_BYTE = 8'h0D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  out_byte;
    logic [15:0] field_number;
    logic        crlf_ending;
    logic        last_of_run;
  } out_item_t;

endpackage

@@ hdl/dfs_fifo.sv @@
// ----------------------------------------------------------------------------
// dfs_fifo: small register queue
// Parts the input side from the splitting engine and the engine from the
// result side; one write and one read a cycle.
// ----------------------------------------------------------------------------
module dfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_r;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hdl/dfs_engine.sv @@
// ----------------------------------------------------------------------------
// dfs_engine: separator matching and event sequencing
// Holds the lookahead window and stream flags; while the result queue has
// room, takes one decision step and produces at most one event a cycle. The
// last event of a beat is held in a tail stage until it is known to be last.
// ----------------------------------------------------------------------------
module dfs_engine #(
  parameter int MAX_SEP_LEN    = 4,
  parameter int FIELD_NUM_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [dfs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dfs_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 item_valid,
  input  dfs_pkg::in_item_t                    item,
  output logic                                 item_take,
  input  logic                                 ev_full,
  output logic                                 ev_push,
  output dfs_pkg::out_item_t                   ev_item
);
  import dfs_pkg::*;

  localparam int LIM = (MAX_SEP_LEN < 4) ? MAX_SEP_LEN : 4;
  localparam int CW  = $clog2(MAX_SEP_LEN + 1);
  localparam logic [2:0] LIM3 = 3'(LIM);
  localparam logic [FIELD_NUM_BITS-1:0] FMAX = '1;

  typedef logic [MAX_SEP_LEN-1:0][7:0] win_t;

  // configuration
  logic [31:0] rsb_r, fsb_r, cmb_r;
  logic [2:0]  rsl_r, fsl_r, cml_r;
  logic        col_r, acr_r;

  // stream state
  win_t                      win_r, win_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [FIELD_NUM_BITS-1:0] fcnt_r, fcnt_nxt;
  logic start_r, start_nxt, cmt_r, cmt_nxt, skip_r, skip_nxt;
  logic held_r, held_nxt, has_r, has_nxt, fed_r, fed_nxt;
  logic busy_r, busy_nxt, eoi_r, eoi_nxt;
  logic      tv_r, tv_nxt;
  out_item_t tail_r, tail_nxt;

  // step signals
  logic [2:0]  rs_len, fs_len, cm_len, dep, k;
  logic [31:0] rs_bytes;
  logic        go, active, eoi_e, work, cons, done, ev_v, fe_need;
  logic        rs_hit, fs_hit, cm_hit;
  win_t        win_e, win_s;
  logic [CW-1:0] cnt_e;
  logic [FIELD_NUM_BITS-1:0] fpos;
  logic [31:0] fpos32;
  out_item_t   ev;

  function automatic logic head_match(win_t w, logic [CW-1:0] c, logic [31:0] p,
                                      logic [2:0] len);
    logic m;
    m = (4'(c) >= 4'(len));
    for (int i = 0; i < LIM; i++) begin
      if ((3'(i) < len) && (w[i] != p[8*i +: 8])) begin
        m = 1'b0;
      end
    end
    return m;
  endfunction

  always_comb begin
    rs_len = acr_r ? 3'd1 : (rsl_r == 3'd0) ? 3'd1 : (rsl_r > LIM3) ? LIM3 : rsl_r;
    fs_len = (fsl_r == 3'd0) ? 3'd1 : (fsl_r > LIM3) ? LIM3 : fsl_r;
    cm_len = (cml_r > LIM3) ? LIM3 : cml_r;
    dep    = rs_len;
    if (fs_len > dep) dep = fs_len;
    if (cm_len > dep) dep = cm_len;
    rs_bytes = acr_r ? 32'(LF_BYTE) : rsb_r;
  end

  assign fpos   = (fcnt_r == FMAX) ? FMAX : fcnt_r + 1'b1;
  assign fpos32 = 32'(fpos);

  assign go        = !ev_full;
  assign active    = go && (busy_r || item_valid);
  assign item_take = go && !busy_r && item_valid;

  // effective window: append the new byte when a beat is taken
  always_comb begin
    win_e = win_r;
    cnt_e = cnt_r;
    eoi_e = busy_r ? eoi_r : item.end_of_input;
    if (!busy_r && !item.end_of_input && (4'(cnt_r) < 4'(MAX_SEP_LEN))) begin
      for (int i = 0; i < MAX_SEP_LEN; i++) begin
        if (cnt_r == CW'(i)) win_e[i] = item.in_byte;
      end
      cnt_e = cnt_r + 1'b1;
    end
  end

  assign rs_hit = head_match(win_e, cnt_e, rs_bytes, rs_len);
  assign fs_hit = head_match(win_e, cnt_e, fsb_r, fs_len);
  assign cm_hit = head_match(win_e, cnt_e, cmb_r, cm_len);

  always_comb begin
    work      = eoi_e ? (cnt_e != '0) : ((cnt_e != '0) && (4'(cnt_e) >= 4'(dep)));
    fe_need   = !(col_r && !has_r);
    k         = 3'd0;
    cons      = 1'b0;
    done      = 1'b0;
    ev_v      = 1'b0;
    ev        = '0;
    fcnt_nxt  = fcnt_r;
    start_nxt = start_r;
    cmt_nxt   = cmt_r;
    skip_nxt  = skip_r;
    held_nxt  = held_r;
    has_nxt   = has_r;
    fed_nxt   = fed_r;
    cnt_nxt   = cnt_e;
    if (!work) begin
      if (!eoi_e) begin
        done = 1'b1;
      end else if (held_r) begin
        ev_v = 1'b1;
        ev.event_kind   = KIND_BYTE;
        ev.out_byte     = CR_BYTE;
        ev.field_number = fpos32[15:0];
        held_nxt = 1'b0;
        has_nxt  = 1'b1;
      end else if (!start_r && !cmt_r && fe_need && !fed_r) begin
        ev_v = 1'b1;
        ev.event_kind   = KIND_FIELD_END;
        ev.field_number = fpos32[15:0];
        fed_nxt = 1'b1;
      end else begin
        // close the open record if any, then return the stream to reset
        if (!start_r && !cmt_r) begin
          ev_v = 1'b1;
          ev.event_kind = KIND_RECORD_END;
        end
        done      = 1'b1;
        cnt_nxt   = '0;
        fcnt_nxt  = '0;
        start_nxt = 1'b1;
        cmt_nxt   = 1'b0;
        skip_nxt  = 1'b0;
        held_nxt  = 1'b0;
        has_nxt   = 1'b0;
        fed_nxt   = 1'b0;
      end
    end else if (cmt_r) begin
      cons = 1'b1;
      if (rs_hit) begin
        k = rs_len;
        cmt_nxt   = 1'b0;
        start_nxt = 1'b1;
      end else begin
        k = 3'd1;
      end
    end else if (start_r && (cm_len != 3'd0) && cm_hit) begin
      cons    = 1'b1;
      k       = cm_len;
      cmt_nxt = 1'b1;
    end else if (held_r && !(rs_hit && acr_r)) begin
      // release the held carriage return ahead of whatever follows
      ev_v = 1'b1;
      ev.event_kind   = KIND_BYTE;
      ev.out_byte     = CR_BYTE;
      ev.field_number = fpos32[15:0];
      held_nxt = 1'b0;
      has_nxt  = 1'b1;
    end else if (rs_hit) begin
      if (fe_need && !fed_r) begin
        ev_v = 1'b1;
        ev.event_kind   = KIND_FIELD_END;
        ev.field_number = fpos32[15:0];
        fed_nxt = 1'b1;
      end else begin
        ev_v = 1'b1;
        ev.event_kind  = KIND_RECORD_END;
        ev.crlf_ending = held_r && acr_r;
        cons      = 1'b1;
        k         = rs_len;
        fcnt_nxt  = '0;
        has_nxt   = 1'b0;
        skip_nxt  = 1'b0;
        start_nxt = 1'b1;
        held_nxt  = 1'b0;
        fed_nxt   = 1'b0;
      end
    end else if (fs_hit) begin
      cons = 1'b1;
      k    = fs_len;
      start_nxt = 1'b0;
      if (!(col_r && (skip_r || start_r))) begin
        ev_v = 1'b1;
        ev.event_kind   = KIND_FIELD_END;
        ev.field_number = fpos32[15:0];
        if (fcnt_r != FMAX) fcnt_nxt = fcnt_r + 1'b1;
        has_nxt  = 1'b0;
        skip_nxt = 1'b1;
      end
    end else begin
      cons = 1'b1;
      k    = 3'd1;
      if (acr_r && (win_e[0] == CR_BYTE)) begin
        held_nxt = 1'b1;
      end else begin
        ev_v = 1'b1;
        ev.event_kind   = KIND_BYTE;
        ev.out_byte     = win_e[0];
        ev.field_number = fpos32[15:0];
        has_nxt = 1'b1;
      end
      skip_nxt  = 1'b0;
      start_nxt = 1'b0;
    end

    // advance the window past the consumed bytes
    win_s = win_e;
    for (int i = 0; i < MAX_SEP_LEN; i++) begin
      for (int j = 1; j <= LIM; j++) begin
        if ((k == 3'(j)) && (i + j < MAX_SEP_LEN)) win_s[i] = win_e[i + j];
      end
    end
    win_nxt = win_s;
    if (cons) begin
      cnt_nxt = cnt_e - CW'(k);
      if (!eoi_e) begin
        done = !((cnt_nxt != '0) && (4'(cnt_nxt) >= 4'(dep)));
      end
    end
  end

  // tail stage: hold the newest event until the beat's last one is known
  always_comb begin
    ev_push  = 1'b0;
    ev_item  = tail_r;
    tv_nxt   = tv_r;
    tail_nxt = tail_r;
    busy_nxt = busy_r;
    eoi_nxt  = eoi_r;
    if (item_take) begin
      eoi_nxt = item.end_of_input;
    end
    if (active) begin
      busy_nxt = !done;
    end
    if (go) begin
      if (active && ev_v) begin
        ev_push  = tv_r;
        tv_nxt   = 1'b1;
        tail_nxt = ev;
        tail_nxt.last_of_run = done;
      end else if (active && done) begin
        ev_push = tv_r;
        ev_item.last_of_run = 1'b1;
        tv_nxt  = 1'b0;
      end else begin
        ev_push = tv_r && tail_r.last_of_run;
        tv_nxt  = tv_r && !tail_r.last_of_run;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsb_r <= 32'd10;
      rsl_r <= 3'd1;
      fsb_r <= 32'd32;
      fsl_r <= 3'd1;
      col_r <= 1'b1;
      acr_r <= 1'b0;
      cmb_r <= 32'd0;
      cml_r <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RECORD_SEP_BYTES: rsb_r <= cfg_data;
        REG_RECORD_SEP_LEN:   rsl_r <= cfg_data[2:0];
        REG_FIELD_SEP_BYTES:  fsb_r <= cfg_data;
        REG_FIELD_SEP_LEN:    fsl_r <= cfg_data[2:0];
        REG_COLLAPSE_REPEATS: col_r <= cfg_data[0];
        REG_AUTO_CRLF:        acr_r <= cfg_data[0];
        REG_COMMENT_BYTES:    cmb_r <= cfg_data;
        REG_COMMENT_LEN:      cml_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      fcnt_r  <= '0;
      start_r <= 1'b1;
      cmt_r   <= 1'b0;
      skip_r  <= 1'b0;
      held_r  <= 1'b0;
      has_r   <= 1'b0;
      fed_r   <= 1'b0;
      busy_r  <= 1'b0;
      eoi_r   <= 1'b0;
      tv_r    <= 1'b0;
    end else begin
      if (active) begin
        cnt_r   <= cnt_nxt;
        fcnt_r  <= fcnt_nxt;
        start_r <= start_nxt;
        cmt_r   <= cmt_nxt;
        skip_r  <= skip_nxt;
        held_r  <= held_nxt;
        has_r   <= has_nxt;
        fed_r   <= fed_nxt;
      end
      busy_r <= busy_nxt;
      eoi_r  <= eoi_nxt;
      tv_r   <= tv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      win_r <= win_nxt;
    end
    tail_r <= tail_nxt;
  end

endmodule

@@ hdl/delimited_field_splitter_unit.sv @@
// ----------------------------------------------------------------------------
// delimited_field_splitter_unit: byte stream to records and numbered fields
// Input queue, splitting engine with lookahead window, result queue.
// ----------------------------------------------------------------------------
//  channel  ports                         beat
//  input    push, full, in_data           one byte or end of input
//  result   empty, pop, out_data          one event
//  config   cfg_we, cfg_index, cfg_data   one register write
//
// A byte that yields at most one event leaves the engine free for the next
// byte: one byte a cycle while the result queue has room. Each further event
// of a beat holds off the next beat, as the engine makes one decision step
// and one event a cycle. End of input works off the bytes left in the window,
// then releases a held CR, ends the last field and closes the open record.
// Reset is synchronous and restores the register defaults and stream state.
// full rises when the input queue fills; the engine halts while the result
// queue is full and resumes without loss.
// ----------------------------------------------------------------------------
module delimited_field_splitter_unit #(
  parameter int MAX_SEP_LEN    = 4,
  parameter int FIELD_NUM_BITS = 16,
  parameter int IN_DEPTH       = 4,
  parameter int OUT_DEPTH      = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  dfs_pkg::in_item_t              in_data,
  output logic                           empty,
  input  logic                           pop,
  output dfs_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [dfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dfs_pkg::*;

  in_item_t  item;
  out_item_t ev_item;
  logic      in_empty, item_take, ev_push, ev_full;

  dfs_fifo #(.WIDTH($bits(in_item_t)), .DEPTH(IN_DEPTH)) u_in_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (in_data),
    .full    (full),
    .rd_en   (item_take),
    .rd_data (item),
    .empty   (in_empty)
  );

  dfs_engine #(.MAX_SEP_LEN(MAX_SEP_LEN), .FIELD_NUM_BITS(FIELD_NUM_BITS)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (!in_empty),
    .item       (item),
    .item_take  (item_take),
    .ev_full    (ev_full),
    .ev_push    (ev_push),
    .ev_item    (ev_item)
  );

  dfs_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ev_push),
    .wr_data (ev_item),
    .full    (ev_full),
    .rd_en   (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule
